[hw/rtl/expression_tokenizer_unit_assert.svh]
// Assertion macros shared by the tokenizer modules.
`ifndef EXPRESSION_TOKENIZER_UNIT_ASSERT_SVH
`define EXPRESSION_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ETOK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ETOK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/etok_pkg.sv]
// Types, character codes and token helpers of the expression tokenizer.
package etok_pkg;

  localparam int unsigned MAX_EXPR_LEN = 4096;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned NUM_SLOTS    = 3;

  typedef enum logic [2:0] {
    KIND_FUNC    = 3'd0,
    KIND_OP      = 3'd1,
    KIND_BRACKET = 3'd2,
    KIND_FLOAT   = 3'd3,
    KIND_INT     = 3'd4,
    KIND_VAR     = 3'd5,
    KIND_END     = 3'd6
  } token_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNKNOWN = 2'd1,
    ERR_OP_SEQ  = 2'd2,
    ERR_BRACKET = 2'd3
  } error_e;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;

  localparam logic [23:0] NAME_SIN = 24'h73696E;
  localparam logic [23:0] NAME_COS = 24'h636F73;
  localparam logic [23:0] NAME_TG  = 24'h007467;
  localparam logic [23:0] NAME_CTG = 24'h637467;

  localparam logic [7:0] FN_SIN = 8'd0;
  localparam logic [7:0] FN_COS = 8'd1;
  localparam logic [7:0] FN_TG  = 8'd2;
  localparam logic [7:0] FN_CTG = 8'd3;

  typedef struct packed {
    token_kind_e kind;
    error_e      err;
    logic [7:0]  symbol;
    logic [11:0] start;
    logic [12:0] length;
    logic        last;
  } token_t;

  // Up to three tokens caused by one character, in emission order.
  typedef struct packed {
    logic [NUM_SLOTS-1:0]   valid;
    token_t [NUM_SLOTS-1:0] slot;
  } record_t;

  // Kind and symbol of a closing run; start and length are filled by the caller.
  function automatic token_t run_token(input logic        is_name,
                                       input logic        has_dot,
                                       input logic        has_digit,
                                       input logic        len2,
                                       input logic        len3,
                                       input logic [23:0] prefix);
    token_t t;
    t      = '0;
    t.kind = KIND_VAR;
    t.err  = ERR_NONE;
    if (is_name) begin
      if (len3 && prefix == NAME_SIN) begin
        t.kind   = KIND_FUNC;
        t.symbol = FN_SIN;
      end else if (len3 && prefix == NAME_COS) begin
        t.kind   = KIND_FUNC;
        t.symbol = FN_COS;
      end else if (len2 && prefix == NAME_TG) begin
        t.kind   = KIND_FUNC;
        t.symbol = FN_TG;
      end else if (len3 && prefix == NAME_CTG) begin
        t.kind   = KIND_FUNC;
        t.symbol = FN_CTG;
      end
    end else if (has_digit) begin
      t.kind = has_dot ? KIND_FLOAT : KIND_INT;
    end
    return t;
  endfunction

endpackage

[hw/rtl/etok_char_if.sv]
// Character input channel of the expression tokenizer.
interface etok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_expression;

  modport source (output valid, output char_code, output end_of_expression, input ready);
  modport sink   (input valid, input char_code, input end_of_expression, output ready);
endinterface

[hw/rtl/etok_token_if.sv]
// Token output channel of the expression tokenizer.
interface etok_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [1:0]  error_code;
  logic [7:0]  symbol;
  logic [11:0] token_start;
  logic [12:0] token_length;
  logic        last;

  modport source (output valid, output token_kind, output error_code, output symbol,
                  output token_start, output token_length, output last, input ready);
  modport sink   (input valid, input token_kind, input error_code, input symbol,
                  input token_start, input token_length, input last, output ready);
endinterface

[hw/rtl/etok_queue.sv]
// Short record queue between the classifying front and the emitting back.
`include "expression_tokenizer_unit_assert.svh"

module etok_queue
  import etok_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  record_t rec_i,
  output logic    ready_o,
  input  logic    pop_i,
  output record_t rec_o,
  output logic    nonempty_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  record_t         mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign ready_o    = (cnt_q != CntFull);
  assign nonempty_o = (cnt_q != '0);
  assign rec_o      = mem_q[rd_q];
  assign do_pop     = pop_i && nonempty_o;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  `ETOK_ASSERT_IMP(a_no_push_full, push_i, cnt_q < CntFull, "record pushed into full queue")

endmodule

[hw/rtl/etok_front.sv]
// Front end: classifies each character, tracks runs and builds token records.
`include "expression_tokenizer_unit_assert.svh"

module etok_front
  import etok_pkg::*;
#(
  parameter int unsigned MaxExprLen = MAX_EXPR_LEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] char_code_i,
  input  logic       eoe_i,
  output logic       push_o,
  output record_t    rec_o
);

  localparam int unsigned CntW = $clog2(MaxExprLen + 1);
  localparam logic [CntW-1:0] CntMax   = CntW'(MaxExprLen);
  localparam logic [CntW-1:0] StartMax = CntW'(MaxExprLen - 1);

  localparam logic [1:0] RUN_NONE = 2'd0;
  localparam logic [1:0] RUN_NUM  = 2'd1;
  localparam logic [1:0] RUN_NAME = 2'd2;

  logic [1:0]      cls_q, cls_d;
  logic [CntW-1:0] start_q, start_d;
  logic [CntW-1:0] len_q, len_d;
  logic [23:0]     prefix_q, prefix_d;
  logic            dot_q, dot_d;
  logic            dig_q, dig_d;
  logic            aop_q, aop_d;
  logic [CntW-1:0] depth_q, depth_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            disc_q, disc_d;

  logic            take;
  logic            is_sp, is_dig, is_alp, is_op, is_num;
  logic            ext_num, ext_name, closing, fail;
  error_e          fail_err;
  logic [CntW-1:0] start_now;
  token_t          tok;
  record_t         rec;

  // Working copy of the run and bracket state after this character.
  logic [1:0]      nr_cls;
  logic [CntW-1:0] nr_start, nr_len, nr_depth, nr_pos;
  logic [23:0]     nr_prefix;
  logic            nr_dot, nr_dig, nr_aop;

  assign take      = in_valid_i && in_ready_i;
  assign start_now = (pos_q < CntMax) ? pos_q : StartMax;

  always_comb begin
    is_sp  = char_code_i inside {[8'd9:8'd13], 8'd32};
    is_dig = char_code_i inside {[8'h30:8'h39]};
    is_alp = char_code_i inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    is_op  = char_code_i inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
    is_num = is_dig || (char_code_i == CH_DOT);

    ext_num  = (cls_q == RUN_NUM) && is_num;
    ext_name = (cls_q == RUN_NAME) && (is_alp || is_dig);
    closing  = !is_sp && !ext_num && !ext_name && (cls_q != RUN_NONE);

    rec      = '0;
    fail     = 1'b0;
    fail_err = ERR_NONE;

    nr_cls    = cls_q;
    nr_start  = start_q;
    nr_len    = len_q;
    nr_prefix = prefix_q;
    nr_dot    = dot_q;
    nr_dig    = dig_q;
    nr_aop    = aop_q;
    nr_depth  = depth_q;
    nr_pos    = pos_q;

    // Emit the open run ahead of the character that breaks it.
    if (closing) begin
      tok = run_token(cls_q == RUN_NAME, dot_q, dig_q, len_q == CntW'(2),
                      len_q == CntW'(3), prefix_q);
      tok.start     = 12'(start_q);
      tok.length    = 13'(len_q);
      rec.valid[0]  = 1'b1;
      rec.slot[0]   = tok;
      nr_cls        = RUN_NONE;
      nr_len        = '0;
      nr_prefix     = '0;
      nr_dot        = 1'b0;
      nr_dig        = 1'b0;
      nr_aop        = 1'b0;
    end

    tok        = '0;
    tok.kind   = KIND_OP;
    tok.err    = ERR_NONE;
    tok.symbol = char_code_i;
    tok.start  = 12'(start_now);
    tok.length = 13'd1;

    if (!is_sp) begin
      if (ext_num) begin
        if (len_q < CntMax) nr_len = len_q + 1'b1;
        if (char_code_i == CH_DOT) nr_dot = 1'b1;
        else nr_dig = 1'b1;
      end else if (ext_name) begin
        if (len_q < CntW'(3)) nr_prefix = {prefix_q[15:0], char_code_i};
        if (len_q < CntMax) nr_len = len_q + 1'b1;
      end else if (is_num || is_alp) begin
        nr_cls    = is_num ? RUN_NUM : RUN_NAME;
        nr_start  = start_now;
        nr_len    = CntW'(1);
        nr_prefix = {16'h0000, char_code_i};
        nr_dot    = (char_code_i == CH_DOT);
        nr_dig    = is_dig;
      end else if (char_code_i == CH_LPAREN || char_code_i == CH_RPAREN) begin
        if (char_code_i == CH_RPAREN && nr_aop) begin
          fail     = 1'b1;
          fail_err = ERR_OP_SEQ;
        end else if (char_code_i == CH_RPAREN && depth_q == '0) begin
          fail     = 1'b1;
          fail_err = ERR_BRACKET;
        end else begin
          if (char_code_i == CH_RPAREN) nr_depth = depth_q - 1'b1;
          else if (depth_q < CntMax) nr_depth = depth_q + 1'b1;
          tok.kind     = KIND_BRACKET;
          rec.valid[1] = 1'b1;
          rec.slot[1]  = tok;
          nr_aop       = 1'b0;
        end
      end else if (is_op) begin
        if (nr_aop) begin
          fail     = 1'b1;
          fail_err = ERR_OP_SEQ;
        end else begin
          rec.valid[1] = 1'b1;
          rec.slot[1]  = tok;
          nr_aop       = 1'b1;
        end
      end else begin
        fail     = 1'b1;
        fail_err = ERR_UNKNOWN;
      end
      if (pos_q < CntMax) nr_pos = pos_q + 1'b1;
    end

    cls_d    = nr_cls;
    start_d  = nr_start;
    len_d    = nr_len;
    prefix_d = nr_prefix;
    dot_d    = nr_dot;
    dig_d    = nr_dig;
    aop_d    = nr_aop;
    depth_d  = nr_depth;
    pos_d    = nr_pos;
    disc_d   = disc_q;

    if (fail) begin
      tok          = '0;
      tok.kind     = KIND_END;
      tok.err      = fail_err;
      tok.start    = 12'(start_now);
      tok.length   = 13'd1;
      tok.last     = 1'b1;
      rec.valid[1] = 1'b1;
      rec.valid[2] = 1'b0;
      rec.slot[1]  = tok;
    end else if (eoe_i) begin
      // Close the run left open by this character, then end the expression.
      if (nr_cls != RUN_NONE) begin
        tok = run_token(nr_cls == RUN_NAME, nr_dot, nr_dig, nr_len == CntW'(2),
                        nr_len == CntW'(3), nr_prefix);
        tok.start    = 12'(nr_start);
        tok.length   = 13'(nr_len);
        rec.valid[1] = 1'b1;
        rec.slot[1]  = tok;
      end
      tok          = '0;
      tok.kind     = KIND_END;
      tok.err      = (nr_depth != '0) ? ERR_BRACKET : ERR_NONE;
      tok.length   = 13'(nr_pos);
      tok.last     = 1'b1;
      rec.valid[2] = 1'b1;
      rec.slot[2]  = tok;
    end

    if (fail || eoe_i) begin
      cls_d    = RUN_NONE;
      start_d  = '0;
      len_d    = '0;
      prefix_d = '0;
      dot_d    = 1'b0;
      dig_d    = 1'b0;
      aop_d    = 1'b0;
      depth_d  = '0;
      pos_d    = '0;
      disc_d   = fail && !eoe_i;
    end

    // Drop everything up to the end of a failed expression.
    if (disc_q) begin
      rec      = '0;
      cls_d    = cls_q;
      start_d  = start_q;
      len_d    = len_q;
      prefix_d = prefix_q;
      dot_d    = dot_q;
      dig_d    = dig_q;
      aop_d    = aop_q;
      depth_d  = depth_q;
      pos_d    = pos_q;
      disc_d   = !eoe_i;
    end
  end

  assign rec_o  = rec;
  assign push_o = take && (rec.valid != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q    <= RUN_NONE;
      start_q  <= '0;
      len_q    <= '0;
      prefix_q <= '0;
      dot_q    <= 1'b0;
      dig_q    <= 1'b0;
      aop_q    <= 1'b0;
      depth_q  <= '0;
      pos_q    <= '0;
      disc_q   <= 1'b0;
    end else if (take) begin
      cls_q    <= cls_d;
      start_q  <= start_d;
      len_q    <= len_d;
      prefix_q <= prefix_d;
      dot_q    <= dot_d;
      dig_q    <= dig_d;
      aop_q    <= aop_d;
      depth_q  <= depth_d;
      pos_q    <= pos_d;
      disc_q   <= disc_d;
    end
  end

  `ETOK_ASSERT_IMP(a_disc_clean, disc_q, cls_q == RUN_NONE && pos_q == '0 && depth_q == '0, "state not cleared while discarding")
  `ETOK_ASSERT_NXT(a_disc_hold, disc_q && !(take && eoe_i), disc_q, "discarding ended before the end of expression")

endmodule

[hw/rtl/etok_back.sv]
// Back end: takes records from the queue and emits their tokens one word at a time.
`include "expression_tokenizer_unit_assert.svh"

module etok_back
  import etok_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  record_t rec_i,
  input  logic    nonempty_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output token_t  out_tok_o
);

  logic [NUM_SLOTS-1:0]   mask_q, mask_d, low, rem;
  token_t [NUM_SLOTS-1:0] slot_q, slot_d;
  logic                   out_take;

  assign out_valid_o = (mask_q != '0);
  assign out_take    = out_valid_o && out_ready_i;
  assign low         = mask_q & (~mask_q + 1'b1);
  assign rem         = out_take ? (mask_q & ~low) : mask_q;
  assign pop_o       = (rem == '0) && nonempty_i;

  always_comb begin
    out_tok_o = slot_q[NUM_SLOTS-1];
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_q[i]) out_tok_o = slot_q[i];
    end
  end

  // Refill as soon as the last pending token of the held record leaves.
  always_comb begin
    mask_d = pop_o ? rec_i.valid : rem;
    slot_d = pop_o ? rec_i.slot : slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  `ETOK_ASSERT_IMP(a_last_is_end, out_valid_o && out_tok_o.last, out_tok_o.kind == KIND_END, "last set on a token that is not an end token")
  `ETOK_ASSERT_IMP(a_err_on_end, out_valid_o && out_tok_o.err != ERR_NONE, out_tok_o.kind == KIND_END && out_tok_o.last, "error code outside an end token")

endmodule

[hw/rtl/expression_tokenizer_unit.sv]
// The first token word of a character is written into the record queue when the character
// is accepted, then loaded into the back end's output register; later words of it follow
// one per cycle while the output is ready. Throughput: one character per cycle while the queue
// has room, and a four-record queue between front and back absorbs bursts.
// The output side emits at most one token word per cycle.
// Reset: asynchronous, active low; clears run state, counters, queue and output valid.
// No clearing pass: the block accepts characters in the first cycle after reset.
module expression_tokenizer_unit
  import etok_pkg::*;
#(
  parameter int unsigned MaxExprLen = MAX_EXPR_LEN
) (
  input logic          clk_i,
  input logic          rst_ni,
  etok_char_if.sink    in_i,
  etok_token_if.source out_o
);

  logic    q_ready, push, pop, nonempty;
  record_t push_rec, head_rec;
  token_t  tok;

  assign in_i.ready = q_ready;

  etok_front #(
    .MaxExprLen(MaxExprLen)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_i (q_ready),
    .char_code_i(in_i.char_code),
    .eoe_i      (in_i.end_of_expression),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  etok_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .rec_i     (push_rec),
    .ready_o   (q_ready),
    .pop_i     (pop),
    .rec_o     (head_rec),
    .nonempty_o(nonempty)
  );

  etok_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_i      (head_rec),
    .nonempty_i (nonempty),
    .pop_o      (pop),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_tok_o  (tok)
  );

  assign out_o.token_kind   = tok.kind;
  assign out_o.error_code   = tok.err;
  assign out_o.symbol       = tok.symbol;
  assign out_o.token_start  = tok.start;
  assign out_o.token_length = tok.length;
  assign out_o.last         = tok.last;

endmodule
